[design/ntgs_pkg.sv]
// Shared types, codes and helper functions for the nested time grant stack.
// No dependencies; every other design file refers to this package by scope.
package ntgs_pkg;

  localparam int FRAME_SLOTS_DEF  = 4;
  localparam int THREAD_COUNT_DEF = 32;
  localparam int CFG_IDX_W        = 8;

  typedef logic [4:0]           thread_t;
  typedef logic [31:0]          cycles_t;
  typedef logic [15:0]          tmin_t;
  typedef logic [23:0]          tmax_t;
  typedef logic [2:0]           depth_field_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam tmin_t TIMER_MIN_RESET = 16'd16;
  localparam tmax_t TIMER_MAX_RESET = 24'hFFFFFF;

  localparam cfg_idx_t CFG_TIMER_MIN = 8'd0;
  localparam cfg_idx_t CFG_TIMER_MAX = 8'd1;

  localparam logic [1:0] CLAIM_OK           = 2'd0;
  localparam logic [1:0] CLAIM_NOT_READY    = 2'd1;
  localparam logic [1:0] CLAIM_BAD_AFFINITY = 2'd2;
  localparam logic [1:0] CLAIM_SPARE        = 2'd3;

  typedef enum logic [1:0] {
    OP_GRANT  = 2'd0,
    OP_SWITCH = 2'd1,
    OP_UNWIND = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_SMALL        = 3'd2,
    ST_NOT_READY    = 3'd3,
    ST_BAD_AFFINITY = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    thread_t    target_thread;
    cycles_t    budget_cycles;
    logic [1:0] claim_status;
  } item_t;

  typedef struct packed {
    logic [2:0]   status;
    thread_t      running_thread;
    logic         unwound;
    thread_t      returned_lender;
    thread_t      borrower_thread;
    logic         end_reason;
    logic         switch_request;
    depth_field_t stack_depth;
  } result_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [31:0] data;
  } cfg_t;

  // Command broadcast to every frame cell.
  typedef struct packed {
    logic    charge;
    cycles_t used;
    logic    push;
    logic    pop;
  } cell_cmd_t;

  // Bound a chunk to the timer range; the minimum wins when the range is inverted.
  function automatic cycles_t clamp_chunk(cycles_t c, tmin_t tmin, tmax_t tmax);
    cycles_t lo;
    cycles_t hi;
    cycles_t r;
    lo = cycles_t'(tmin);
    hi = cycles_t'(tmax);
    if (c < lo) begin
      r = lo;
    end else if (c > hi) begin
      r = (hi < lo) ? lo : hi;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic status_t claim_error(logic in_range, logic [1:0] claim);
    status_t s;
    if (!in_range) begin
      s = ST_NOT_READY;
    end else if (claim == CLAIM_OK) begin
      s = ST_OK;
    end else if (claim == CLAIM_BAD_AFFINITY) begin
      s = ST_BAD_AFFINITY;
    end else begin
      s = ST_NOT_READY;
    end
    return s;
  endfunction

endpackage

[design/ntgs_item_if.sv]
// Input item channel: valid/ready handshake with an item payload.
// Depends on ntgs_pkg.
interface ntgs_item_if;
  logic            valid;
  logic            ready;
  ntgs_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/ntgs_result_if.sv]
// Result channel: valid/ready handshake with a result payload.
// Depends on ntgs_pkg.
interface ntgs_result_if;
  logic              valid;
  logic              ready;
  ntgs_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/ntgs_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on ntgs_pkg.
interface ntgs_cfg_if;
  logic           valid;
  logic           ready;
  ntgs_pkg::cfg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/ntgs_cell.sv]
// One grant frame of the stack chain: lender and remaining budget.
// Shifts toward its neighbors on push/pop and charges used time. Depends on ntgs_pkg.
module ntgs_cell (
  input  logic                clk,
  input  ntgs_pkg::cell_cmd_t cmd,
  input  ntgs_pkg::thread_t   left_lender,
  input  ntgs_pkg::cycles_t   left_remaining,
  input  ntgs_pkg::thread_t   right_lender,
  input  ntgs_pkg::cycles_t   right_remaining,
  output ntgs_pkg::thread_t   lender,
  output ntgs_pkg::cycles_t   remaining
);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      lender    <= left_lender;
      remaining <= left_remaining;
    end else if (cmd.pop) begin
      lender    <= right_lender;
      remaining <= right_remaining;
    end else if (cmd.charge) begin
      // saturate at zero
      remaining <= (remaining > cmd.used) ? remaining - cmd.used : '0;
    end
  end

endmodule

[design/nested_time_grant_stack.sv]
// Nested time grant stack for one core. Each item passes through an accept and an apply
// state: the accept state charges the used time into every frame cell of the chain and
// steps the one-shot countdown, the apply state applies the operation (push, pop, switch
// or rearm) and loads the result register. A new item is taken while the result register
// is empty or being drained, and never while the previous item is being applied.
// Frames live in a row of FRAME_SLOTS cells with the innermost frame in the first
// cell; frame contents are not cleared by reset and need no clearing pass.
module nested_time_grant_stack #(
  parameter int FRAME_SLOTS  = ntgs_pkg::FRAME_SLOTS_DEF,
  parameter int THREAD_COUNT = ntgs_pkg::THREAD_COUNT_DEF
) (
  input logic            clk,
  input logic            rst,
  ntgs_item_if.sink      in,
  ntgs_result_if.source  out,
  ntgs_cfg_if.sink       cfg
);

  localparam int DEPTH_W = $clog2(FRAME_SLOTS + 1);

  typedef enum logic {S_ACCEPT, S_APPLY} state_t;

  state_t                state;
  logic [DEPTH_W-1:0]    depth;
  ntgs_pkg::thread_t     cur;
  ntgs_pkg::cycles_t     armed;
  ntgs_pkg::cycles_t     countdown;
  ntgs_pkg::tmin_t       timer_min;
  ntgs_pkg::tmax_t       timer_max;
  ntgs_pkg::item_t       item;
  logic                  tick_expired;
  logic                  out_valid;
  ntgs_pkg::result_t     out_payload;

  // cell outputs; the extra slot past the last cell reads as zero
  ntgs_pkg::thread_t     cell_lender [0:FRAME_SLOTS];
  ntgs_pkg::cycles_t     cell_rem    [0:FRAME_SLOTS];
  ntgs_pkg::cell_cmd_t   cell_cmd;

  logic                  accept;
  logic                  depth_full;
  logic                  depth_empty;
  logic                  tick_live;
  ntgs_pkg::cycles_t     cd_new;
  logic                  charge_en;
  logic                  sub_en;
  ntgs_pkg::cycles_t     used;

  logic                  in_range;
  ntgs_pkg::status_t     claim_st;
  logic                  same_thread;
  ntgs_pkg::cycles_t     top;
  ntgs_pkg::cycles_t     below;
  logic                  use_top;
  ntgs_pkg::cycles_t     budget;
  logic                  too_small;
  ntgs_pkg::cycles_t     chunk_budget;
  ntgs_pkg::cycles_t     chunk_top;
  ntgs_pkg::cycles_t     chunk_below;

  logic                  do_push;
  logic                  do_pop;
  logic [DEPTH_W-1:0]    depth_next;
  ntgs_pkg::thread_t     cur_next;
  ntgs_pkg::cycles_t     armed_next;
  ntgs_pkg::cycles_t     countdown_next;
  ntgs_pkg::result_t     res;

  assign in.ready    = (state == S_ACCEPT) && (!out_valid || out.ready);
  assign accept      = in.valid && in.ready;
  assign cfg.ready   = 1'b1;
  assign out.valid   = out_valid;
  assign out.payload = out_payload;

  assign depth_full  = (depth == DEPTH_W'(FRAME_SLOTS));
  assign depth_empty = (depth == '0);

  // Charge cycle: step the countdown and work out the time used since the last charge.
  always_comb begin
    tick_live = (in.payload.op == ntgs_pkg::OP_TICK) && (countdown != '0);
    cd_new    = tick_live ? countdown - 32'd1 : countdown;
    charge_en = ((in.payload.op == ntgs_pkg::OP_GRANT) &&
                 (in.payload.target_thread != cur) && !depth_full) ||
                (((in.payload.op == ntgs_pkg::OP_SWITCH) ||
                  (in.payload.op == ntgs_pkg::OP_UNWIND)) && !depth_empty) ||
                (tick_live && (countdown == 32'd1));
    sub_en    = !depth_empty && (armed != '0);
    if (cd_new == '0) begin
      used = armed;
    end else if (cd_new > armed) begin
      used = '0;
    end else begin
      used = armed - cd_new;
    end
  end

  // Apply cycle: operands from the charged frames.
  always_comb begin
    in_range     = 32'(item.target_thread) < 32'(THREAD_COUNT);
    claim_st     = ntgs_pkg::claim_error(in_range, item.claim_status);
    same_thread  = (item.target_thread == cur);
    top          = cell_rem[0];
    below        = cell_rem[1];
    use_top      = !depth_empty && (top < item.budget_cycles);
    budget       = use_top ? top : item.budget_cycles;
    too_small    = use_top ? (top < ntgs_pkg::cycles_t'(timer_min))
                           : (item.budget_cycles < ntgs_pkg::cycles_t'(timer_min));
    chunk_top    = ntgs_pkg::clamp_chunk(top, timer_min, timer_max);
    chunk_below  = ntgs_pkg::clamp_chunk(below, timer_min, timer_max);
    chunk_budget = use_top ? chunk_top
                           : ntgs_pkg::clamp_chunk(item.budget_cycles, timer_min, timer_max);
  end

  always_comb begin
    res            = '0;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    depth_next     = depth;
    cur_next       = cur;
    armed_next     = armed;
    countdown_next = countdown;
    case (item.op)
      ntgs_pkg::OP_GRANT: begin
        if (!same_thread) begin
          if (depth_full) begin
            res.status = ntgs_pkg::ST_FULL;
          end else if (too_small) begin
            res.status = ntgs_pkg::ST_SMALL;
          end else if (claim_st != ntgs_pkg::ST_OK) begin
            res.status = claim_st;
          end else begin
            do_push        = 1'b1;
            depth_next     = depth + DEPTH_W'(1);
            cur_next       = item.target_thread;
            armed_next     = chunk_budget;
            countdown_next = chunk_budget;
          end
        end
      end
      ntgs_pkg::OP_SWITCH, ntgs_pkg::OP_UNWIND: begin
        if (!depth_empty) begin
          do_pop              = 1'b1;
          res.unwound         = 1'b1;
          res.borrower_thread = cur;
          res.returned_lender = cell_lender[0];
          res.end_reason      = (item.op == ntgs_pkg::OP_UNWIND);
          depth_next          = depth - DEPTH_W'(1);
          cur_next            = cell_lender[0];
          if (depth == DEPTH_W'(1)) begin
            armed_next     = '0;
            countdown_next = '0;
          end else if (below == '0) begin
            res.switch_request = 1'b1;
          end else begin
            armed_next     = chunk_below;
            countdown_next = chunk_below;
          end
        end else if ((item.op == ntgs_pkg::OP_SWITCH) && !same_thread) begin
          res.status = claim_st;
          if (claim_st == ntgs_pkg::ST_OK) begin
            cur_next = item.target_thread;
          end
        end
      end
      ntgs_pkg::OP_TICK: begin
        // expiry: rearm with the next chunk, or ask for an unwind once spent
        if (tick_expired && !depth_empty) begin
          if (top == '0) begin
            armed_next         = '0;
            countdown_next     = '0;
            res.switch_request = 1'b1;
          end else begin
            armed_next     = chunk_top;
            countdown_next = chunk_top;
          end
        end
      end
      default: begin
      end
    endcase
    res.running_thread = cur_next;
    res.stack_depth    = ntgs_pkg::depth_field_t'(depth_next);
  end

  always_comb begin
    cell_cmd.charge = accept && charge_en && sub_en;
    cell_cmd.used   = used;
    cell_cmd.push   = (state == S_APPLY) && do_push;
    cell_cmd.pop    = (state == S_APPLY) && do_pop;
  end

  assign cell_lender[FRAME_SLOTS] = '0;
  assign cell_rem[FRAME_SLOTS]    = '0;

  for (genvar i = 0; i < FRAME_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      ntgs_cell u_cell (
        .clk             (clk),
        .cmd             (cell_cmd),
        .left_lender     (cur),
        .left_remaining  (budget),
        .right_lender    (cell_lender[i+1]),
        .right_remaining (cell_rem[i+1]),
        .lender          (cell_lender[i]),
        .remaining       (cell_rem[i])
      );
    end else begin : g_body
      ntgs_cell u_cell (
        .clk             (clk),
        .cmd             (cell_cmd),
        .left_lender     (cell_lender[i-1]),
        .left_remaining  (cell_rem[i-1]),
        .right_lender    (cell_lender[i+1]),
        .right_remaining (cell_rem[i+1]),
        .lender          (cell_lender[i]),
        .remaining       (cell_rem[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCEPT;
      depth     <= '0;
      cur       <= '0;
      armed     <= '0;
      countdown <= '0;
      timer_min <= ntgs_pkg::TIMER_MIN_RESET;
      timer_max <= ntgs_pkg::TIMER_MAX_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.payload.index)
          ntgs_pkg::CFG_TIMER_MIN: timer_min <= cfg.payload.data[15:0];
          ntgs_pkg::CFG_TIMER_MAX: timer_max <= cfg.payload.data[23:0];
          default: begin
          end
        endcase
      end
      // drop the result once transferred
      if (out_valid && out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ACCEPT: begin
          if (accept) begin
            item         <= in.payload;
            tick_expired <= tick_live && (countdown == 32'd1);
            countdown    <= cd_new;
            if (charge_en) begin
              armed <= sub_en ? cd_new : '0;
            end
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          depth       <= depth_next;
          cur         <= cur_next;
          armed       <= armed_next;
          countdown   <= countdown_next;
          out_payload <= res;
          out_valid   <= 1'b1;
          state       <= S_ACCEPT;
        end
        default: begin
          state <= S_ACCEPT;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_countdown_within_chunk: assert property (@(posedge clk) disable iff (rst)
    countdown <= armed)
    else $error("countdown above armed chunk");

  a_depth_bounded: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(FRAME_SLOTS))
    else $error("stack depth above maximum");

  a_push_grows_depth: assert property (@(posedge clk) disable iff (rst)
    cell_cmd.push |=> depth == ($past(depth) + DEPTH_W'(1)))
    else $error("push did not grow the stack by one");

  a_no_take_while_applying: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> !in.ready && !cell_cmd.charge)
    else $error("item taken or charged during apply cycle");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for nested_time_grant_stack: directed cases, then random grant,
// tick, switch and unwind traffic under several timer settings, with a built-in predictor.
// Depends on ntgs_pkg and the item, result and config channel interfaces.
`timescale 1ns / 1ps

module tb;

  localparam int NDEPTH      = ntgs_pkg::FRAME_SLOTS_DEF;
  localparam int NTHREADS    = ntgs_pkg::THREAD_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // Tracks the grant stack, predicts each result and checks the block against it.
  class grant_scoreboard;
    ntgs_pkg::thread_t lender_of [NDEPTH];
    ntgs_pkg::cycles_t left [NDEPTH];
    int unsigned       depth;
    ntgs_pkg::thread_t running;
    ntgs_pkg::cycles_t chunk;
    ntgs_pkg::cycles_t count;
    ntgs_pkg::cycles_t tmin;
    ntgs_pkg::cycles_t tmax;
    ntgs_pkg::result_t pending [$];
    int unsigned       errors;
    int unsigned       shown;
    int unsigned       results;
    int unsigned       pushes;
    int unsigned       pops;
    int unsigned       alarms;

    function new();
      for (int i = 0; i < NDEPTH; i++) begin
        lender_of[i] = '0;
        left[i]      = '0;
      end
      depth   = 0;
      running = '0;
      chunk   = '0;
      count   = '0;
      tmin    = ntgs_pkg::cycles_t'(ntgs_pkg::TIMER_MIN_RESET);
      tmax    = ntgs_pkg::cycles_t'(ntgs_pkg::TIMER_MAX_RESET);
      errors  = 0;
      shown   = 0;
      results = 0;
      pushes  = 0;
      pops    = 0;
      alarms  = 0;
    endfunction

    function void set_reg(ntgs_pkg::cfg_idx_t idx, logic [31:0] data);
      if (idx == ntgs_pkg::CFG_TIMER_MIN) begin
        tmin = ntgs_pkg::cycles_t'(data[15:0]);
      end else if (idx == ntgs_pkg::CFG_TIMER_MAX) begin
        tmax = ntgs_pkg::cycles_t'(data[23:0]);
      end
    endfunction

    // Subtract the time spent in the current chunk from every stacked frame.
    function void charge_frames(bit expired);
      ntgs_pkg::cycles_t used;
      if (depth == 0 || chunk == 0) begin
        chunk = '0;
        return;
      end
      if (expired || count == 0) begin
        used = chunk;
      end else if (count > chunk) begin
        used = '0;
      end else begin
        used = chunk - count;
      end
      for (int i = 0; i < depth; i++) begin
        left[i] = (left[i] > used) ? left[i] - used : '0;
      end
      chunk = expired ? '0 : count;
    endfunction

    // Load the countdown from the innermost frame; the minimum is applied last.
    function void load_countdown();
      ntgs_pkg::cycles_t c;
      if (depth == 0) begin
        chunk = '0;
        count = '0;
        return;
      end
      c = left[depth-1];
      if (c > tmax) begin
        c = tmax;
      end
      if (c < tmin) begin
        c = tmin;
      end
      chunk = c;
      count = c;
    endfunction

    function bit pop_frame(output ntgs_pkg::thread_t lend, output ntgs_pkg::thread_t borrow,
                           inout bit sreq);
      lend   = '0;
      borrow = '0;
      if (depth == 0) begin
        return 1'b0;
      end
      charge_frames(1'b0);
      borrow  = running;
      lend    = lender_of[depth-1];
      depth   = depth - 1;
      running = lend;
      if (depth == 0) begin
        chunk = '0;
        count = '0;
      end else if (left[depth-1] == 0) begin
        sreq = 1'b1;
      end else begin
        load_countdown();
      end
      return 1'b1;
    endfunction

    function ntgs_pkg::status_t claim_code(ntgs_pkg::thread_t t, logic [1:0] c);
      if (int'(t) >= NTHREADS) begin
        return ntgs_pkg::ST_NOT_READY;
      end
      if (c == ntgs_pkg::CLAIM_OK) begin
        return ntgs_pkg::ST_OK;
      end else if (c == ntgs_pkg::CLAIM_BAD_AFFINITY) begin
        return ntgs_pkg::ST_BAD_AFFINITY;
      end
      return ntgs_pkg::ST_NOT_READY;
    endfunction

    function void note_item(ntgs_pkg::item_t it);
      ntgs_pkg::result_t r;
      ntgs_pkg::status_t st;
      bit                popped;
      bit                sreq;
      ntgs_pkg::thread_t lend;
      ntgs_pkg::thread_t borrow;
      logic              reason;
      ntgs_pkg::cycles_t budget;
      st     = ntgs_pkg::ST_OK;
      popped = 1'b0;
      sreq   = 1'b0;
      lend   = '0;
      borrow = '0;
      reason = 1'b0;
      case (ntgs_pkg::op_t'(it.op))
        ntgs_pkg::OP_GRANT: begin
          if (it.target_thread != running) begin
            if (depth >= NDEPTH) begin
              st = ntgs_pkg::ST_FULL;
            end else begin
              charge_frames(1'b0);
              budget = it.budget_cycles;
              if (depth != 0 && left[depth-1] < budget) begin
                budget = left[depth-1];
              end
              if (budget < tmin) begin
                st = ntgs_pkg::ST_SMALL;
              end else begin
                st = claim_code(it.target_thread, it.claim_status);
                if (st == ntgs_pkg::ST_OK) begin
                  lender_of[depth] = running;
                  left[depth]      = budget;
                  depth            = depth + 1;
                  running          = it.target_thread;
                  load_countdown();
                  pushes++;
                end
              end
            end
          end
        end
        ntgs_pkg::OP_SWITCH: begin
          // While borrowing, a switch hands the innermost grant back early.
          if (depth != 0) begin
            popped = pop_frame(lend, borrow, sreq);
          end else if (it.target_thread != running) begin
            st = claim_code(it.target_thread, it.claim_status);
            if (st == ntgs_pkg::ST_OK) begin
              running = it.target_thread;
            end
          end
        end
        ntgs_pkg::OP_UNWIND: begin
          popped = pop_frame(lend, borrow, sreq);
          reason = popped;
        end
        default: begin
          if (count != 0) begin
            count = count - 1;
            if (count == 0) begin
              if (depth == 0) begin
                chunk = '0;
              end else begin
                charge_frames(1'b1);
                if (left[depth-1] == 0) begin
                  chunk = '0;
                  count = '0;
                  sreq  = 1'b1;
                end else begin
                  load_countdown();
                end
              end
            end
          end
        end
      endcase
      if (!popped) begin
        lend   = '0;
        borrow = '0;
        reason = 1'b0;
      end
      r.status          = st;
      r.running_thread  = running;
      r.unwound         = popped;
      r.returned_lender = lend;
      r.borrower_thread = borrow;
      r.end_reason      = reason;
      r.switch_request  = sreq;
      r.stack_depth     = ntgs_pkg::depth_field_t'(depth);
      pending.push_back(r);
    endfunction

    function void same_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        errors++;
        if (shown < 40) begin
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
        end
        shown++;
      end
    endfunction

    function void check_result(ntgs_pkg::result_t got);
      ntgs_pkg::result_t exp;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 40) begin
          $display("%0t: result with nothing pending: expected none, actual %h", $time, got);
        end
        shown++;
        return;
      end
      exp = pending.pop_front();
      if (exp.unwound) begin
        pops++;
      end
      if (exp.switch_request) begin
        alarms++;
      end
      same_field("status", 32'(exp.status), 32'(got.status));
      same_field("running_thread", 32'(exp.running_thread), 32'(got.running_thread));
      same_field("unwound", 32'(exp.unwound), 32'(got.unwound));
      same_field("returned_lender", 32'(exp.returned_lender), 32'(got.returned_lender));
      same_field("borrower_thread", 32'(exp.borrower_thread), 32'(got.borrower_thread));
      same_field("end_reason", 32'(exp.end_reason), 32'(got.end_reason));
      same_field("switch_request", 32'(exp.switch_request), 32'(got.switch_request));
      same_field("stack_depth", 32'(exp.stack_depth), 32'(got.stack_depth));
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  int unsigned     cycles = 0;
  bit              calm = 1'b0;
  grant_scoreboard sb;

  ntgs_item_if   in_if ();
  ntgs_result_if out_if ();
  ntgs_cfg_if    cfg_if ();

  nested_time_grant_stack #(
    .FRAME_SLOTS  (NDEPTH),
    .THREAD_COUNT (NTHREADS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .out (out_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result sink: stall at random unless in a calm stretch.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.payload);
    end
  end

  function automatic ntgs_pkg::item_t mk(ntgs_pkg::op_t op, int tgt,
                                         ntgs_pkg::cycles_t bud, logic [1:0] cl);
    ntgs_pkg::item_t it;
    it.op            = op;
    it.target_thread = ntgs_pkg::thread_t'(tgt);
    it.budget_cycles = bud;
    it.claim_status  = cl;
    return it;
  endfunction

  // Mostly well-formed grant/tick traffic sized to the current minimum, plus noise.
  function automatic ntgs_pkg::item_t rand_item();
    ntgs_pkg::item_t it;
    int unsigned     pick;
    int unsigned     lim;
    it.target_thread = ntgs_pkg::thread_t'($urandom_range(NTHREADS - 1));
    it.claim_status  = ($urandom_range(99) < 80) ? ntgs_pkg::CLAIM_OK
                                                 : 2'($urandom_range(3));
    it.budget_cycles = $urandom;
    pick = $urandom_range(99);
    if (pick < 18) begin
      it.op = ntgs_pkg::OP_GRANT;
      if (it.target_thread == sb.running && $urandom_range(99) < 85) begin
        it.target_thread =
          ntgs_pkg::thread_t'(sb.running + 1 + $urandom_range(NTHREADS - 2));
      end
      lim = sb.tmin * 4 + 8;
      case ($urandom_range(9))
        7:       it.budget_cycles = $urandom_range(1) ? sb.tmin : sb.tmin - 1;
        8:       it.budget_cycles = 32'hFFFF_FFFF;
        9:       it.budget_cycles = $urandom;
        default: it.budget_cycles = $urandom_range(lim);
      endcase
    end else if (pick < 24) begin
      it.op = ntgs_pkg::OP_SWITCH;
    end else if (pick < 28) begin
      it.op = ntgs_pkg::OP_UNWIND;
    end else if (pick < 31) begin
      it.op           = 2'($urandom_range(3));
      it.claim_status = 2'($urandom_range(3));
    end else begin
      it.op = ntgs_pkg::OP_TICK;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with
  // valid still high, so a back-to-back item keeps it asserted.
  task automatic send_item(ntgs_pkg::item_t it);
    while (!calm && $urandom_range(99) < 34) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(ntgs_pkg::cfg_idx_t idx, logic [31:0] data);
    ntgs_pkg::cfg_t c;
    c.index = idx;
    c.data  = data;
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= c;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timer(ntgs_pkg::tmin_t lo, ntgs_pkg::tmax_t hi);
    in_if.valid <= 1'b0;
    drain();
    write_reg(ntgs_pkg::CFG_TIMER_MIN, 32'(lo));
    write_reg(ntgs_pkg::CFG_TIMER_MAX, 32'(hi));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(ntgs_pkg::tmin_t lo, ntgs_pkg::tmax_t hi, int n, int calm_n);
    set_timer(lo, hi);
    for (int i = 0; i < n; i++) begin
      calm = (i < calm_n);
      send_item(rand_item());
    end
    calm = 1'b0;
  endtask

  initial begin
    ntgs_pkg::item_t plan [$];
    sb = new();
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Short timer range so the directed grants expire within a few ticks.
    set_timer(16'd3, 24'd5);
    // countdown idle, nothing stacked, switch to self
    plan.push_back(mk(ntgs_pkg::OP_TICK,   0, 32'd0, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_UNWIND, 0, 32'd0, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_SWITCH, 0, 32'd0, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_SWITCH, 3, 32'd0, ntgs_pkg::CLAIM_NOT_READY));
    plan.push_back(mk(ntgs_pkg::OP_SWITCH, 3, 32'd0, ntgs_pkg::CLAIM_BAD_AFFINITY));
    plan.push_back(mk(ntgs_pkg::OP_SWITCH, 3, 32'd0, ntgs_pkg::CLAIM_SPARE));
    plan.push_back(mk(ntgs_pkg::OP_SWITCH, 3, 32'd0, ntgs_pkg::CLAIM_OK));
    // grant to self, then below minimum
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  3, 32'd100, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  7, 32'd2, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  7, 32'd0, ntgs_pkg::CLAIM_SPARE));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  7, 32'hFFFF_FFFF, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  9, 32'd6, ntgs_pkg::CLAIM_NOT_READY));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  9, 32'd6, ntgs_pkg::CLAIM_BAD_AFFINITY));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  9, 32'd6, ntgs_pkg::CLAIM_OK));
    // clamped to outer frame
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  31, 32'd1000, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  17, 32'd3, ntgs_pkg::CLAIM_OK));
    // stack full
    plan.push_back(mk(ntgs_pkg::OP_GRANT,  5, 32'd30, ntgs_pkg::CLAIM_OK));
    repeat (3) plan.push_back(mk(ntgs_pkg::OP_TICK, 0, 32'd0, ntgs_pkg::CLAIM_OK));
    plan.push_back(mk(ntgs_pkg::OP_UNWIND, 0, 32'd0, ntgs_pkg::CLAIM_OK));
    // yield while borrowing
    plan.push_back(mk(ntgs_pkg::OP_SWITCH, 12, 32'd0, ntgs_pkg::CLAIM_OK));
    foreach (plan[i]) begin
      send_item(plan[i]);
    end

    run_phase(16'd16, 24'hFFFFFF, 300, 0);
    run_phase(16'd1, 24'd1, 200, 0);
    run_phase(16'd20, 24'd5, 180, 0);
    run_phase(16'hFFFF, 24'hFFFFFF, 120, 0);
    run_phase(16'd2, 24'd7, 320, 160);
    run_phase(16'd1, 24'hFFFFFF, 200, 0);

    in_if.valid <= 1'b0;
    drain();
    $display("Checked %0d results over 7 timer settings: %0d grants stacked,",
             sb.results, sb.pushes);
    $display("%0d frames unwound, %0d budget exhaustions, %0d errors.",
             sb.pops, sb.alarms, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ntgs_pkg.sv
design/ntgs_item_if.sv
design/ntgs_result_if.sv
design/ntgs_cfg_if.sv
design/ntgs_cell.sv
design/nested_time_grant_stack.sv
tb/tb.sv
